>>> hw/rtl/lcdt_pkg.sv
// Shared types, constants and helpers of the LCD mode timing controller.
`default_nettype none

package lcdt_pkg;

   // Frame geometry.
   localparam int VISIBLE_LINES = 144;

   localparam int LINE_W   = 8;
   localparam int COUNT_W  = 13;
   localparam int PHASE_W  = 9;
   localparam int BATCH_W  = 8;
   localparam int INTEN_W  = 4;
   localparam int CODE_W   = 2;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 4;

   localparam logic [COUNT_W-1:0] OAM_CLOCKS    = COUNT_W'(80);
   localparam logic [COUNT_W-1:0] XFER_CLOCKS   = COUNT_W'(172);
   localparam logic [COUNT_W-1:0] HBLANK_CLOCKS = COUNT_W'(204);
   localparam logic [COUNT_W-1:0] VBLANK_CLOCKS = COUNT_W'(4560);
   localparam logic [PHASE_W:0]   LINE_CLOCKS   = (PHASE_W+1)'(456);

   localparam logic [LINE_W-1:0]  LAST_VISIBLE  = LINE_W'(VISIBLE_LINES);

   // Mode codes as reported on the video_mode field.
   localparam logic [CODE_W-1:0] CODE_HBLANK = 2'd0;
   localparam logic [CODE_W-1:0] CODE_VBLANK = 2'd1;
   localparam logic [CODE_W-1:0] CODE_OAM    = 2'd2;
   localparam logic [CODE_W-1:0] CODE_XFER   = 2'd3;

   // Status interrupt enable bits.
   localparam int INTEN_HBLANK  = 0;
   localparam int INTEN_VBLANK  = 1;
   localparam int INTEN_OAM     = 2;
   localparam int INTEN_COMPARE = 3;

   typedef enum logic [3:0] {
      MODE_HBLANK = 4'b0001,
      MODE_VBLANK = 4'b0010,
      MODE_OAM    = 4'b0100,
      MODE_XFER   = 4'b1000
   } mode_type;

   typedef enum logic [1:0] {
      REG_LCD_ENABLE   = 2'd0,
      REG_STAT_ENABLES = 2'd1,
      REG_LINE_COMPARE = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic                  lcd_enable;
      logic [INTEN_W-1:0]    stat_int_enables;
      logic [LINE_W-1:0]     line_compare;
   } cfg_type;

   typedef struct packed {
      mode_type              mode;
      logic [COUNT_W-1:0]    count;
      logic [PHASE_W-1:0]    phase;   // count modulo one line, kept in vblank
      logic [LINE_W-1:0]     line;
      logic                  vram_open;
      logic                  oam_open;
   } timing_type;

   typedef struct packed {
      logic [LINE_W-1:0]     current_line;
      logic [CODE_W-1:0]     video_mode;
      logic [LINE_W-1:0]     status_byte;
      logic                  vblank_request;
      logic                  status_request;
      logic                  frame_done;
      logic                  line_done;
      logic                  vram_open;
      logic                  oam_open;
   } result_type;

   function automatic logic [CODE_W-1:0] mode_code(input mode_type mode);
      logic [CODE_W-1:0] code;
      unique case (mode)
         MODE_HBLANK: code = CODE_HBLANK;
         MODE_VBLANK: code = CODE_VBLANK;
         MODE_OAM:    code = CODE_OAM;
         MODE_XFER:   code = CODE_XFER;
         default:     code = CODE_OAM;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lcd_mode_timing_controller.sv
// Top level of the LCD mode timing controller: request pipeline, registers, state.
`default_nettype none

// LCD mode timing controller. Each request carries a batch of 0 to 255 dot
// clocks; each request yields exactly one response with the current line,
// video mode, status byte, vblank and LCD status interrupt requests, frame and
// line pulses, and the processor access flags for video memory and OAM.
// The block sequences OAM scan, transfer and hblank per visible line, then
// vblank over ten lines after the last visible line. Clocks that run past a
// mode limit are dropped. With the display off the line reads 0 and the mode
// and clock count are held. One request per clock is taken while rsp_stall
// does not hold the response register. A request passes through the input
// register, then the mode step and status logic, which also writes back the
// timing state, then the response register. While a response waits on
// rsp_stall, one more request can enter an empty input stage, which stalls
// only when both stages are full. Registers sit on an APB-style port
// (lcd_enable at 0x0, stat_int_enables at 0x4, line_compare at 0x8); write
// them only while no request is in flight.

module lcd_mode_timing_controller (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lcdt_pkg::BATCH_W-1:0]     req_clock_batch,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lcdt_pkg::LINE_W-1:0]      rsp_current_line,
   output logic [lcdt_pkg::CODE_W-1:0]      rsp_video_mode,
   output logic [lcdt_pkg::LINE_W-1:0]      rsp_status_byte,
   output logic                             rsp_vblank_request,
   output logic                             rsp_status_request,
   output logic                             rsp_frame_done,
   output logic                             rsp_line_done,
   output logic                             rsp_vram_open,
   output logic                             rsp_oam_open,
   // configuration port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lcdt_pkg::ADDR_W-1:0]      paddr,
   input  logic [lcdt_pkg::DATA_W-1:0]      pwdata,
   output logic [lcdt_pkg::DATA_W-1:0]      prdata,
   output logic                             pready
);
   import lcdt_pkg::*;

   // configuration registers
   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   reg_index_type        reg_index;
   logic                 cfg_write;

   // input stage
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [BATCH_W-1:0]   s1_batch_ff;
   logic                 s1_load;
   logic                 advance;

   // timing state and response stage
   timing_type           state_ff;
   timing_type           state_in;
   timing_type           state_step;
   result_type           rsp_ff;
   result_type           rsp_step;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;

   // ---------------------------------------------------------------------
   // Configuration port: always ready, write on the access phase.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[ADDR_W-1:2]);
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (reg_index)
            REG_LCD_ENABLE:   cfg_in.lcd_enable       = pwdata[0];
            REG_STAT_ENABLES: cfg_in.stat_int_enables = pwdata[INTEN_W-1:0];
            REG_LINE_COMPARE: cfg_in.line_compare     = pwdata[LINE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_LCD_ENABLE:   prdata = DATA_W'(cfg_ff.lcd_enable);
         REG_STAT_ENABLES: prdata = DATA_W'(cfg_ff.stat_int_enables);
         REG_LINE_COMPARE: prdata = DATA_W'(cfg_ff.line_compare);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lcd_enable       <= 1'b1;
         cfg_ff.stat_int_enables <= '0;
         cfg_ff.line_compare     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control. The input stage moves into the response register
   // when that register is empty or being drained this cycle; the input
   // stage takes a new request whenever it is empty or moving on.
   // ---------------------------------------------------------------------
   assign advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign s1_load      = req_valid && !req_stall;
   assign s1_valid_in  = s1_load || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the batch while the input stage is stalled
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_batch_ff <= req_clock_batch;
      end
   end

   // ---------------------------------------------------------------------
   // Mode step: next timing state and response fields from one batch.
   // ---------------------------------------------------------------------
   lcdt_step u_step (
      .cfg   (cfg_ff),
      .cur   (state_ff),
      .batch (s1_batch_ff),
      .nxt   (state_step),
      .res   (rsp_step)
   );

   // advance the timing state only when the request moves on
   assign state_in = advance ? state_step : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode      <= MODE_OAM;
         state_ff.count     <= '0;
         state_ff.phase     <= '0;
         state_ff.line      <= '0;
         state_ff.vram_open <= 1'b1;
         state_ff.oam_open  <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_step;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_current_line   = rsp_ff.current_line;
   assign rsp_video_mode     = rsp_ff.video_mode;
   assign rsp_status_byte    = rsp_ff.status_byte;
   assign rsp_vblank_request = rsp_ff.vblank_request;
   assign rsp_status_request = rsp_ff.status_request;
   assign rsp_frame_done     = rsp_ff.frame_done;
   assign rsp_line_done      = rsp_ff.line_done;
   assign rsp_vram_open      = rsp_ff.vram_open;
   assign rsp_oam_open       = rsp_ff.oam_open;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // the vblank line phase never reaches a full line
   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase < PHASE_W'(LINE_CLOCKS))
      else $error("vblank line phase out of range");

   // a frame pulse comes with a vblank request and the vblank mode
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_vblank_request && (rsp_video_mode == CODE_VBLANK))
      else $error("frame pulse without vblank entry");

   // a line pulse leaves both memories open in hblank
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |->
         rsp_vram_open && rsp_oam_open && (rsp_video_mode == CODE_HBLANK))
      else $error("line pulse without hblank entry");

   // the timing state changes only when a request moves to the response stage
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("timing state changed without a request");

endmodule

`default_nettype wire

>>> hw/rtl/lcdt_step.sv
// Next-state and result logic for one batch of dot clocks.
`default_nettype none

module lcdt_step (
   input  lcdt_pkg::cfg_type              cfg,
   input  lcdt_pkg::timing_type           cur,
   input  logic [lcdt_pkg::BATCH_W-1:0]   batch,
   output lcdt_pkg::timing_type           nxt,
   output lcdt_pkg::result_type           res
);
   import lcdt_pkg::*;

   logic [COUNT_W-1:0]  sum;
   logic [PHASE_W:0]    phase_sum;
   logic [LINE_W-1:0]   line_inc;
   logic                inc_hit;
   logic                vblank_req;
   logic                stat_req;
   logic                frame;
   logic                line_pulse;

   assign sum       = cur.count + COUNT_W'(batch);
   assign phase_sum = {1'b0, cur.phase} + (PHASE_W+1)'(batch);
   assign line_inc  = cur.line + LINE_W'(1);
   assign inc_hit   = cfg.stat_int_enables[INTEN_COMPARE] && (line_inc == cfg.line_compare);

   always_comb begin
      nxt        = cur;
      vblank_req = 1'b0;
      stat_req   = 1'b0;
      frame      = 1'b0;
      line_pulse = 1'b0;
      if (!cfg.lcd_enable) begin
         nxt.line = '0;
      end else begin
         nxt.count = sum;
         unique case (cur.mode)
            MODE_HBLANK: begin
               if (sum >= HBLANK_CLOCKS) begin
                  nxt.count = '0;
                  nxt.line  = line_inc;
                  nxt.phase = '0;
                  if (line_inc >= LAST_VISIBLE) begin
                     nxt.mode      = MODE_VBLANK;
                     vblank_req    = 1'b1;
                     stat_req      = cfg.stat_int_enables[INTEN_VBLANK];
                     nxt.vram_open = 1'b1;
                     nxt.oam_open  = 1'b1;
                     frame         = 1'b1;
                  end else begin
                     nxt.mode      = MODE_OAM;
                     stat_req      = cfg.stat_int_enables[INTEN_OAM];
                     nxt.vram_open = 1'b1;
                     nxt.oam_open  = 1'b0;
                  end
                  if (inc_hit) begin
                     stat_req = 1'b1;
                  end
               end
            end
            MODE_VBLANK: begin
               if (sum >= VBLANK_CLOCKS) begin
                  nxt.count     = '0;
                  nxt.phase     = '0;
                  nxt.mode      = MODE_OAM;
                  stat_req      = cfg.stat_int_enables[INTEN_OAM];
                  nxt.vram_open = 1'b1;
                  nxt.oam_open  = 1'b0;
                  nxt.line      = '0;
               end else if (phase_sum >= LINE_CLOCKS) begin
                  // crossed a line boundary: advance the line
                  nxt.phase = PHASE_W'(phase_sum - LINE_CLOCKS);
                  nxt.line  = line_inc;
                  stat_req  = inc_hit;
               end else begin
                  nxt.phase = phase_sum[PHASE_W-1:0];
               end
            end
            MODE_OAM: begin
               if (sum >= OAM_CLOCKS) begin
                  nxt.count     = '0;
                  nxt.mode      = MODE_XFER;
                  nxt.vram_open = 1'b0;
                  nxt.oam_open  = 1'b0;
               end
            end
            MODE_XFER: begin
               if (sum >= XFER_CLOCKS) begin
                  nxt.count     = '0;
                  nxt.mode      = MODE_HBLANK;
                  stat_req      = cfg.stat_int_enables[INTEN_HBLANK];
                  nxt.vram_open = 1'b1;
                  nxt.oam_open  = 1'b1;
                  line_pulse    = 1'b1;
               end
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
   end

   always_comb begin
      res.current_line   = nxt.line;
      res.video_mode     = mode_code(nxt.mode);
      res.status_byte    = {1'b1, cfg.stat_int_enables, (nxt.line == cfg.line_compare),
                            (cfg.lcd_enable ? mode_code(nxt.mode) : CODE_HBLANK)};
      res.vblank_request = vblank_req;
      res.status_request = stat_req;
      res.frame_done     = frame;
      res.line_done      = line_pulse;
      res.vram_open      = nxt.vram_open;
      res.oam_open       = nxt.oam_open;
   end

endmodule

`default_nettype wire
